// ----- sv/jis_pkg.sv -----
// Package for the joint impedance step block: codes, register layout,
// command and configuration types, and shared fixed-point constants.
// Depends on nothing; every other file imports it.
package jis_pkg;

    // Operand and product widths of the shared signed multiplier.
    localparam int OPW   = 33;
    localparam int PRODW = 2 * OPW;

    // Q16.16 and Q1.16 constants.
    localparam logic [16:0]        Q_ONE    = 17'd65536;
    localparam logic signed [31:0] PCT_FULL = 32'sd6553600;
    localparam logic [22:0]        PCT_HALF = 23'd50;
    localparam logic [6:0]         PCT_DIV  = 7'd100;
    // floor(2^30 / 100): reciprocal for the percent conversion.
    localparam logic signed [OPW-1:0] RECIP_100 = 33'sd10737418;
    localparam int RECIP_SHIFT = 30;

    // Register reset values.
    localparam logic [30:0] RST_INV_INERTIA = 31'd65536;
    localparam logic [30:0] RST_DAMPING     = 31'd655360;
    localparam logic [30:0] RST_STIFF_MIN   = 31'd0;
    localparam logic [30:0] RST_STIFF_MAX   = 31'd0;
    localparam logic [30:0] RST_DEADBAND    = 31'd0;
    localparam logic [16:0] RST_FILTER      = 17'd64881;
    localparam logic [31:0] RST_TIME_STEP   = 32'd4294967;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_REC     = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        REG_INV_INERTIA = 3'd0,
        REG_DAMPING     = 3'd1,
        REG_STIFF_MIN   = 3'd2,
        REG_STIFF_MAX   = 3'd3,
        REG_DEADBAND    = 3'd4,
        REG_FILTER      = 3'd5,
        REG_TIME_STEP   = 3'd6
    } reg_idx_t;

    // Multiplier operand selection.
    typedef enum logic [3:0] {
        MUL_NONE   = 4'd0,
        MUL_FILT   = 4'd1,
        MUL_DAMP   = 4'd2,
        MUL_INTERP = 4'd3,
        MUL_VDT    = 4'd4,
        MUL_KERR   = 4'd5,
        MUL_INERT  = 4'd6,
        MUL_ADT    = 4'd7,
        MUL_DVDT   = 4'd8,
        MUL_REC    = 4'd9
    } mul_sel_t;

    // Which datapath registers take an update this cycle.
    typedef enum logic [3:0] {
        UPD_NONE  = 4'd0,
        UPD_LOAD  = 4'd1,
        UPD_PREP  = 4'd2,
        UPD_FILT  = 4'd3,
        UPD_DAMP  = 4'd4,
        UPD_STIFF = 4'd5,
        UPD_VDT   = 4'd6,
        UPD_FORCE = 4'd7,
        UPD_ACC   = 4'd8,
        UPD_DV    = 4'd9,
        UPD_STATE = 4'd10,
        UPD_REC   = 4'd11
    } upd_sel_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        upd_sel_t upd_sel;
    } cmd_t;

    typedef struct packed {
        logic [30:0] inv_inertia;
        logic [30:0] damping;
        logic [30:0] stiff_min;
        logic [30:0] stiff_max;
        logic [30:0] deadband;
        logic [16:0] filter;
        logic [31:0] time_step;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] target_position;
        logic signed [31:0] target_velocity;
        logic signed [31:0] external_torque;
        logic signed [31:0] recommendation;
    } in_item_t;

endpackage

// ----- sv/joint_impedance_step.sv -----
// Top level of the joint impedance step: stream ports, configuration
// registers and the output register around jis_ctrl and jis_dp.
// Depends on jis_pkg, jis_ctrl and jis_dp.
//
//   Channel   Direction  Beat carries
//   s_*       in         operation (tuser), setpoint, torque, recommendation
//   m_*       out        command position and velocity after a control tick
//   cfg_*     in         register index and write data
//
// A control tick walks its beat through twelve steps of the sequencer, set
// by the single shared 33x33 multiplier whose product is registered between
// dependent operations, and then waits in ST_OUT to hand over its result. A
// recommendation passes through ST_REC1 and ST_REC2, a restart only clears
// the configured flag, and the first tick after reset or restart loads the state.
// Reset is synchronous and active low; it restores configuration, sequencer,
// filter and motion state and valid flag, not data; no clearing pass follows.
// The block takes a new beat while a result still waits in the output
// register; a later result waits inside the block until that register frees.
module joint_impedance_step
    import jis_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, from bit 0: target_position[31:0], target_velocity[63:32],
    // external_torque[95:64], recommendation[127:96].
    input  logic [127:0] s_tdata,
    // tuser: operation[1:0].
    input  logic [1:0]   s_tuser,

    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata, from bit 0: command_position[31:0], command_velocity[63:32].
    output logic [63:0]  m_tdata,

    // Configuration writes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    in_item_t in_item;
    cmd_t     cmd;
    logic     in_accept, in_ready, out_load, out_free;
    logic     m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic signed [31:0] position, velocity;

    // Always accepted; the user writes only while the block is idle, unenforced.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_INV_INERTIA: cfg_next.inv_inertia = cfg_data[30:0];
                REG_DAMPING:     cfg_next.damping     = cfg_data[30:0];
                REG_STIFF_MIN:   cfg_next.stiff_min   = cfg_data[30:0];
                REG_STIFF_MAX:   cfg_next.stiff_max   = cfg_data[30:0];
                REG_DEADBAND:    cfg_next.deadband    = cfg_data[30:0];
                REG_FILTER:      cfg_next.filter      = cfg_data[16:0];
                REG_TIME_STEP:   cfg_next.time_step   = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_inertia <= RST_INV_INERTIA;
            cfg_reg.damping     <= RST_DAMPING;
            cfg_reg.stiff_min   <= RST_STIFF_MIN;
            cfg_reg.stiff_max   <= RST_STIFF_MAX;
            cfg_reg.deadband    <= RST_DEADBAND;
            cfg_reg.filter      <= RST_FILTER;
            cfg_reg.time_step   <= RST_TIME_STEP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input beat unpacking.
    assign in_accept = s_tvalid & in_ready;
    assign s_tready  = in_ready;

    assign in_item.target_position = $signed(s_tdata[31:0]);
    assign in_item.target_velocity = $signed(s_tdata[63:32]);
    assign in_item.external_torque = $signed(s_tdata[95:64]);
    assign in_item.recommendation  = $signed(s_tdata[127:96]);

    jis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_accept),
        .op       (op_t'(s_tuser)),
        .out_free (out_free),
        .in_ready (in_ready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    jis_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_load  (in_accept),
        .in_item  (in_item),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .position (position),
        .velocity (velocity)
    );

    // Output register: free when empty or when its beat leaves this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {velocity, position};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- sv/jis_ctrl.sv -----
// Controller of the joint impedance step: one-hot sequencer that walks each
// item through the shared multiplier schedule and owns the configured flag.
// Depends on jis_pkg.
module jis_ctrl
    import jis_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic start,      // an input beat is taken this cycle
    input  op_t  op,
    input  logic out_free,   // output register can take a result
    output logic in_ready,
    output logic out_load,
    output cmd_t cmd
);

    typedef enum logic [16:0] {
        ST_IDLE   = 17'h00001,
        ST_LOAD   = 17'h00002,
        ST_REC1   = 17'h00004,
        ST_REC2   = 17'h00008,
        ST_PREP   = 17'h00010,
        ST_FILT   = 17'h00020,
        ST_INTERP = 17'h00040,
        ST_STIFF  = 17'h00080,
        ST_KERR   = 17'h00100,
        ST_FORCE  = 17'h00200,
        ST_INERT  = 17'h00400,
        ST_ACC    = 17'h00800,
        ST_ADT    = 17'h01000,
        ST_DV     = 17'h02000,
        ST_DVDT   = 17'h04000,
        ST_STATE  = 17'h08000,
        ST_OUT    = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    logic   configured_reg, configured_next;

    always_comb begin
        state_next      = state_reg;
        configured_next = configured_reg;
        cmd.mul_sel     = MUL_NONE;
        cmd.upd_sel     = UPD_NONE;
        out_load        = 1'b0;
        in_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (start) begin
                    unique case (op)
                        OP_TICK:    state_next = configured_reg ? ST_PREP : ST_LOAD;
                        OP_REC:     state_next = ST_REC1;
                        OP_RESTART: configured_next = 1'b0;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                cmd.upd_sel     = UPD_LOAD;
                configured_next = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_REC1: begin
                cmd.mul_sel = MUL_REC;
                state_next  = ST_REC2;
            end
            ST_REC2: begin
                cmd.upd_sel = UPD_REC;
                state_next  = ST_IDLE;
            end
            ST_PREP: begin
                cmd.mul_sel = MUL_FILT;
                cmd.upd_sel = UPD_PREP;
                state_next  = ST_FILT;
            end
            ST_FILT: begin
                cmd.mul_sel = MUL_DAMP;
                cmd.upd_sel = UPD_FILT;
                state_next  = ST_INTERP;
            end
            ST_INTERP: begin
                cmd.mul_sel = MUL_INTERP;
                cmd.upd_sel = UPD_DAMP;
                state_next  = ST_STIFF;
            end
            ST_STIFF: begin
                cmd.mul_sel = MUL_VDT;
                cmd.upd_sel = UPD_STIFF;
                state_next  = ST_KERR;
            end
            ST_KERR: begin
                cmd.mul_sel = MUL_KERR;
                cmd.upd_sel = UPD_VDT;
                state_next  = ST_FORCE;
            end
            ST_FORCE: begin
                cmd.upd_sel = UPD_FORCE;
                state_next  = ST_INERT;
            end
            ST_INERT: begin
                cmd.mul_sel = MUL_INERT;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.upd_sel = UPD_ACC;
                state_next  = ST_ADT;
            end
            ST_ADT: begin
                cmd.mul_sel = MUL_ADT;
                state_next  = ST_DV;
            end
            ST_DV: begin
                cmd.upd_sel = UPD_DV;
                state_next  = ST_DVDT;
            end
            ST_DVDT: begin
                cmd.mul_sel = MUL_DVDT;
                state_next  = ST_STATE;
            end
            ST_STATE: begin
                cmd.upd_sel = UPD_STATE;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            configured_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            configured_reg <= configured_next;
        end
    end

endmodule

// ----- sv/jis_dp.sv -----
// Datapath of the joint impedance step: captured item, filter and motion
// state, one shared 33x33 signed multiplier with a registered product.
// Depends on jis_pkg; driven by commands from jis_ctrl.
module jis_dp
    import jis_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_load,
    input  in_item_t           in_item,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    output logic signed [31:0] position,
    output logic signed [31:0] velocity
);

    function automatic logic signed [PRODW-1:0] rnd16(input logic signed [PRODW-1:0] p);
        return (p + 66'sd32768) >>> 16;
    endfunction

    function automatic logic signed [PRODW-1:0] rnd32(input logic signed [PRODW-1:0] p);
        return (p + 66'sd2147483648) >>> 32;
    endfunction

    function automatic logic signed [PRODW-1:0] rnd33(input logic signed [PRODW-1:0] p);
        return (p + 66'sd4294967296) >>> 33;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PRODW-1:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    // Captured item.
    logic signed [31:0] tp_reg, tp_next, tv_reg, tv_next;
    logic signed [31:0] tq_reg, tq_next, rec_reg, rec_next;

    // Persistent state.
    logic signed [31:0] pos_reg, pos_next, vel_reg, vel_next;
    logic        [16:0] targ_reg, targ_next, filt_reg, filt_next;

    // Intermediate values of one tick.
    logic signed [31:0] tqdb_reg, tqdb_next;
    logic signed [32:0] err_p_reg, err_p_next, err_v_reg, err_v_next;
    logic signed [49:0] force_acc_reg, force_acc_next;
    logic signed [32:0] stiff_reg, stiff_next;
    logic signed [33:0] pos_acc_reg, pos_acc_next;
    logic signed [31:0] force_reg, force_next, acc_reg, acc_next;
    logic signed [32:0] dv_reg, dv_next;

    logic signed [PRODW-1:0] prod_reg, prod_next;
    logic signed [OPW-1:0]   mul_a, mul_b;

    logic        [16:0]      coef_sat;
    logic signed [17:0]      filt_diff;
    logic signed [32:0]      tq_ext, db_ext;
    logic        [22:0]      rec_n;
    logic        [16:0]      quot;
    logic        [23:0]      quot100, rem;
    logic signed [PRODW-1:0] filt_sum;

    assign coef_sat  = (cfg.filter > Q_ONE) ? Q_ONE : cfg.filter;
    assign filt_diff = $signed({1'b0, filt_reg}) - $signed({1'b0, targ_reg});
    assign tq_ext    = 33'(tq_reg);
    assign db_ext    = $signed({2'b00, cfg.deadband});
    assign rec_n     = rec_reg[22:0] + PCT_HALF;
    assign quot      = prod_reg[RECIP_SHIFT+16:RECIP_SHIFT];
    assign quot100   = {1'b0, quot, 6'd0} + {2'b00, quot, 5'd0} + {5'd0, quot, 2'd0};
    assign rem       = {1'b0, rec_n} - quot100;
    assign filt_sum  = 66'($signed({1'b0, targ_reg})) + rnd16(prod_reg);

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_FILT: begin
                mul_a = $signed({16'd0, coef_sat});
                mul_b = 33'(filt_diff);
            end
            MUL_DAMP: begin
                mul_a = $signed({2'b00, cfg.damping});
                mul_b = err_v_reg;
            end
            MUL_INTERP: begin
                mul_a = $signed({2'b00, cfg.stiff_max}) - $signed({2'b00, cfg.stiff_min});
                mul_b = $signed({16'd0, filt_reg});
            end
            MUL_VDT: begin
                mul_a = 33'(vel_reg);
                mul_b = $signed({1'b0, cfg.time_step});
            end
            MUL_KERR: begin
                mul_a = stiff_reg;
                mul_b = err_p_reg;
            end
            MUL_INERT: begin
                mul_a = $signed({2'b00, cfg.inv_inertia});
                mul_b = 33'(force_reg);
            end
            MUL_ADT: begin
                mul_a = 33'(acc_reg);
                mul_b = $signed({1'b0, cfg.time_step});
            end
            MUL_DVDT: begin
                mul_a = dv_reg;
                mul_b = $signed({1'b0, cfg.time_step});
            end
            MUL_REC: begin
                mul_a = $signed({10'd0, rec_n});
                mul_b = RECIP_100;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb begin
        tp_next        = tp_reg;
        tv_next        = tv_reg;
        tq_next        = tq_reg;
        rec_next       = rec_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        targ_next      = targ_reg;
        filt_next      = filt_reg;
        tqdb_next      = tqdb_reg;
        err_p_next     = err_p_reg;
        err_v_next     = err_v_reg;
        force_acc_next = force_acc_reg;
        stiff_next     = stiff_reg;
        pos_acc_next   = pos_acc_reg;
        force_next     = force_reg;
        acc_next       = acc_reg;
        dv_next        = dv_reg;

        if (in_load) begin
            tp_next  = in_item.target_position;
            tv_next  = in_item.target_velocity;
            tq_next  = in_item.external_torque;
            rec_next = in_item.recommendation;
        end

        unique case (cmd.upd_sel)
            UPD_NONE: begin
            end
            UPD_LOAD: begin
                pos_next = tp_reg;
                vel_next = tv_reg;
            end
            UPD_PREP: begin
                priority if (tq_ext > db_ext) begin
                    tqdb_next = 32'(tq_ext - db_ext);
                end else if (tq_ext < -db_ext) begin
                    tqdb_next = 32'(tq_ext + db_ext);
                end else begin
                    tqdb_next = '0;
                end
                err_p_next = 33'(tp_reg) - 33'(pos_reg);
                err_v_next = 33'(tv_reg) - 33'(vel_reg);
            end
            UPD_FILT:  filt_next = filt_sum[16:0];
            UPD_DAMP:  force_acc_next = 50'(rnd16(prod_reg)) + 50'(tqdb_reg);
            UPD_STIFF: stiff_next = $signed({2'b00, cfg.stiff_min}) + 33'(rnd16(prod_reg));
            UPD_VDT:   pos_acc_next = 34'(pos_reg) + 34'(rnd32(prod_reg));
            UPD_FORCE: force_next = sat32(66'(force_acc_reg) + rnd16(prod_reg));
            UPD_ACC:   acc_next = sat32(rnd16(prod_reg));
            UPD_DV:    dv_next = 33'(rnd32(prod_reg));
            UPD_STATE: begin
                pos_next = sat32(66'(pos_acc_reg) + rnd33(prod_reg));
                vel_next = sat32(66'(vel_reg) + 66'(dv_reg));
            end
            UPD_REC: begin
                priority if (rec_reg > PCT_FULL) begin
                    targ_next = Q_ONE;
                end else if (rec_reg < 0) begin
                    targ_next = '0;
                end else if (rem >= 24'(PCT_DIV)) begin
                    targ_next = quot + 17'd1;
                end else begin
                    targ_next = quot;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            vel_reg  <= '0;
            targ_reg <= Q_ONE;
            filt_reg <= Q_ONE;
        end else begin
            pos_reg  <= pos_next;
            vel_reg  <= vel_next;
            targ_reg <= targ_next;
            filt_reg <= filt_next;
        end
    end

    always_ff @(posedge aclk) begin
        tp_reg        <= tp_next;
        tv_reg        <= tv_next;
        tq_reg        <= tq_next;
        rec_reg       <= rec_next;
        tqdb_reg      <= tqdb_next;
        err_p_reg     <= err_p_next;
        err_v_reg     <= err_v_next;
        force_acc_reg <= force_acc_next;
        stiff_reg     <= stiff_next;
        pos_acc_reg   <= pos_acc_next;
        force_reg     <= force_next;
        acc_reg       <= acc_next;
        dv_reg        <= dv_next;
        prod_reg      <= prod_next;
    end

    assign position = pos_reg;
    assign velocity = vel_reg;

endmodule

// ----- bench/impedance_checker.sv -----
// Scoreboard for the joint impedance step. It follows the configuration,
// input and result channels, predicts every command and compares it.
// Depends on jis_pkg.
module impedance_checker
    import jis_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           mismatch_count,
    output int           commands_pending,
    output int           commands_checked
);

    // Wide enough that no product or sum of the datapath can overflow.
    typedef logic signed [95:0] wide_t;

    typedef struct packed {
        logic signed [31:0] velocity;
        logic signed [31:0] position;
    } command_t;

    localparam wide_t S32_MAX = (wide_t'(1) <<< 31) - 1;
    localparam wide_t S32_MIN = -(wide_t'(1) <<< 31);
    localparam int    REPORT_LIMIT = 10;

    cfg_t               shadow_cfg;
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic [16:0]        adapt_target;
    logic [16:0]        adapt_filtered;
    logic               est_loaded;
    command_t           expected_commands [$];
    int                 bad_results = 0;
    int                 checked = 0;

    function automatic wide_t rounded_shift(wide_t v, int s);
        return (v + (wide_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic wide_t clip_s32(wide_t v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic logic [16:0] percent_to_target(logic signed [31:0] pct);
        if (pct > PCT_FULL) return Q_ONE;
        if (pct < 0) return '0;
        return 17'((wide_t'(pct) + wide_t'(PCT_HALF)) / wide_t'(PCT_DIV));
    endfunction

    // One control tick on a loaded axis: updates the state and returns the command.
    function automatic command_t integrate_tick(in_item_t beat);
        wide_t torque, band, weight, stiffness, net_torque, accel, dt, dv, pos, vel;
        torque = wide_t'(beat.external_torque);
        band   = wide_t'(shadow_cfg.deadband);
        if (torque > band) begin
            torque = torque - band;
        end else if (torque < -band) begin
            torque = torque + band;
        end else begin
            torque = '0;
        end

        weight = (shadow_cfg.filter > Q_ONE) ? wide_t'(Q_ONE) : wide_t'(shadow_cfg.filter);
        adapt_filtered = 17'(rounded_shift(weight * wide_t'(adapt_filtered)
                         + (wide_t'(Q_ONE) - weight) * wide_t'(adapt_target), 16));

        // A minimum above the maximum gives a negative span, as intended.
        stiffness = wide_t'(shadow_cfg.stiff_min)
                  + rounded_shift((wide_t'(shadow_cfg.stiff_max) - wide_t'(shadow_cfg.stiff_min))
                                  * wide_t'(adapt_filtered), 16);

        pos   = wide_t'(est_position);
        vel   = wide_t'(est_velocity);
        net_torque = clip_s32(rounded_shift(stiffness * (wide_t'(beat.target_position) - pos), 16)
                   + rounded_shift(wide_t'(shadow_cfg.damping)
                                   * (wide_t'(beat.target_velocity) - vel), 16)
                   + torque);
        accel = clip_s32(rounded_shift(wide_t'(shadow_cfg.inv_inertia) * net_torque, 16));

        dt = wide_t'(shadow_cfg.time_step);
        dv = rounded_shift(accel * dt, 32);
        est_position = 32'(clip_s32(pos + rounded_shift(vel * dt, 32)
                                    + rounded_shift(dv * dt, 33)));
        est_velocity = 32'(clip_s32(vel + dv));
        return {est_velocity, est_position};
    endfunction

    always @(posedge aclk) begin : track
        in_item_t beat;
        command_t seen;
        command_t want;
        if (!aresetn) begin
            shadow_cfg = '{inv_inertia: RST_INV_INERTIA, damping: RST_DAMPING,
                           stiff_min: RST_STIFF_MIN, stiff_max: RST_STIFF_MAX,
                           deadband: RST_DEADBAND, filter: RST_FILTER,
                           time_step: RST_TIME_STEP};
            est_position   = '0;
            est_velocity   = '0;
            adapt_target   = Q_ONE;
            adapt_filtered = Q_ONE;
            est_loaded     = 1'b0;
            expected_commands.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_INV_INERTIA: shadow_cfg.inv_inertia = cfg_data[30:0];
                    REG_DAMPING:     shadow_cfg.damping     = cfg_data[30:0];
                    REG_STIFF_MIN:   shadow_cfg.stiff_min   = cfg_data[30:0];
                    REG_STIFF_MAX:   shadow_cfg.stiff_max   = cfg_data[30:0];
                    REG_DEADBAND:    shadow_cfg.deadband    = cfg_data[30:0];
                    REG_FILTER:      shadow_cfg.filter      = cfg_data[16:0];
                    REG_TIME_STEP:   shadow_cfg.time_step   = cfg_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                beat.target_position = s_tdata[31:0];
                beat.target_velocity = s_tdata[63:32];
                beat.external_torque = s_tdata[95:64];
                beat.recommendation  = s_tdata[127:96];
                case (s_tuser)
                    OP_TICK: begin
                        if (!est_loaded) begin
                            est_loaded   = 1'b1;
                            est_position = beat.target_position;
                            est_velocity = beat.target_velocity;
                        end else begin
                            expected_commands.push_back(integrate_tick(beat));
                        end
                    end
                    OP_REC:     adapt_target = percent_to_target(beat.recommendation);
                    OP_RESTART: est_loaded = 1'b0;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                seen = m_tdata;
                if (expected_commands.size() == 0) begin
                    bad_results++;
                    if (bad_results <= REPORT_LIMIT)
                        $display("[chk] unexpected command: position %0d velocity %0d",
                                 seen.position, seen.velocity);
                end else begin
                    want = expected_commands.pop_front();
                    checked++;
                    if (seen.position !== want.position || seen.velocity !== want.velocity) begin
                        bad_results++;
                        if (bad_results <= REPORT_LIMIT)
                            $display({"[chk] command %0d wrong: position exp %0d got %0d, ",
                                      "velocity exp %0d got %0d"}, checked,
                                     want.position, seen.position,
                                     want.velocity, seen.velocity);
                    end
                end
            end
        end
        mismatch_count   <= bad_results;
        commands_pending <= expected_commands.size();
        commands_checked <= checked;
    end

endmodule

// ----- bench/tb_joint_impedance_step.sv -----
// Testbench top for the joint impedance step: clock, reset, input beats,
// result back-pressure, register settings and the verdict.
// Depends on jis_pkg, joint_impedance_step and impedance_checker.
module tb_joint_impedance_step;
    import jis_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int MAX_GAP       = 9;
    // This covers any beat that gives no command.
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int REG_COUNT     = int'(REG_TIME_STEP) + 1;

    // Codes the package leaves out: the unused operation and a register
    // index beyond the last register.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] REG_NONE  = 3'd7;

    // Register settings the run moves through.
    typedef enum int {
        PROF_BENCH,     // fixed, readable values for the directed beats
        PROF_TYPICAL,   // random but realistic gains and periods
        PROF_CEILING,   // every register at its largest value
        PROF_ZERO,      // every register at zero, including the time step
        PROF_DOWNWARD,  // minimum stiffness above the maximum, tiny step
        PROF_WILD       // raw random words, plus a write to an unused index
    } profile_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // Fields from bit 0: target_position, target_velocity, external_torque,
    // recommendation.
    logic [127:0] s_tdata = '0;
    // Field: operation.
    logic [1:0]   s_tuser = OP_TICK;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // Fields from bit 0: command_position, command_velocity.
    logic [63:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = REG_INV_INERTIA;
    logic [31:0]  cfg_data = '0;

    int          mismatch_count;
    int          commands_pending;
    int          commands_checked;
    int unsigned cycle_count = 0;
    int          beats_sent = 0;
    int          settings_applied = 0;

    // Idling controls shared between the stimulus and the result sink.
    bit tx_no_idle = 1'b0;
    bit rx_no_idle = 1'b0;
    int rx_hold_cycles = 0;

    always #HALF_PERIOD aclk = ~aclk;

    joint_impedance_step i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    impedance_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .commands_pending(commands_pending),
        .commands_checked(commands_checked)
    );

    // Watchdog: a hung handshake or a lost command ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result sink. Before every command it stalls for a random number of
    // cycles, unless idling is switched off. A requested hold-off replaces
    // one such stall, so the block fills up behind a full output register.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offers one beat after a random gap and returns at the edge that takes
    // it. When there is no gap, valid simply stays high into the next beat.
    task automatic send_beat(input logic [1:0] op, input logic [31:0] tp,
                             input logic [31:0] tv, input logic [31:0] tq,
                             input logic [31:0] pct);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pct, tq, tv, tp};
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes every register according to one profile. Only called while the
    // block is idle.
    task automatic apply_settings(input profile_t prof);
        logic [31:0] vals [REG_COUNT];
        case (prof)
            PROF_BENCH: begin
                vals[REG_INV_INERTIA] = 32'h0001_0000;
                vals[REG_DAMPING]     = 32'h000A_0000;
                vals[REG_STIFF_MIN]   = 32'h0032_0000;
                vals[REG_STIFF_MAX]   = 32'h01F4_0000;
                vals[REG_DEADBAND]    = 32'h0002_0000;
                vals[REG_FILTER]      = 32'd49152;
                vals[REG_TIME_STEP]   = 32'd42949673;
            end
            PROF_TYPICAL: begin
                vals[REG_INV_INERTIA] = $urandom_range(32'h0000_1000, 32'h0004_0000);
                vals[REG_DAMPING]     = $urandom_range(0, 32'h0040_0000);
                vals[REG_STIFF_MIN]   = $urandom_range(0, 32'h0040_0000);
                vals[REG_STIFF_MAX]   = $urandom_range(0, 32'h0200_0000);
                vals[REG_DEADBAND]    = $urandom_range(0, 32'h0004_0000);
                vals[REG_FILTER]      = $urandom_range(0, 32'(Q_ONE));
                vals[REG_TIME_STEP]   = $urandom_range(32'h0010_0000, 32'h0400_0000);
            end
            PROF_CEILING: begin
                // The filter field then reads above one and counts as one.
                for (int r = 0; r < REG_COUNT; r++) vals[r] = '1;
            end
            PROF_ZERO: begin
                for (int r = 0; r < REG_COUNT; r++) vals[r] = '0;
            end
            PROF_DOWNWARD: begin
                vals[REG_INV_INERTIA] = $urandom_range(32'h0000_8000, 32'h0002_0000);
                vals[REG_DAMPING]     = $urandom_range(0, 32'h0010_0000);
                vals[REG_STIFF_MIN]   = $urandom_range(32'h0100_0000, 32'h0400_0000);
                vals[REG_STIFF_MAX]   = $urandom_range(0, 32'h00FF_FFFF);
                vals[REG_DEADBAND]    = $urandom_range(0, 32'h0001_0000);
                vals[REG_FILTER]      = 32'(Q_ONE);
                vals[REG_TIME_STEP]   = 32'd1;
            end
            default: begin
                for (int r = 0; r < REG_COUNT; r++) vals[r] = $urandom();
                write_reg(REG_NONE, $urandom());
            end
        endcase
        for (int r = REG_INV_INERTIA; r <= REG_TIME_STEP; r++) write_reg(3'(r), vals[r]);
        settings_applied++;
    endtask

    // Mostly small values around zero so the axis stays in a useful range,
    // with full-range words and the signed extremes mixed in.
    function automatic logic [31:0] draw_q16();
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            3:       return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
            default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [31:0] draw_percent();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 5))
                    0:       return 32'(PCT_FULL);
                    1:       return 32'(PCT_FULL) + 1;
                    2:       return '0;
                    3:       return '1;
                    4:       return 32'd49;
                    default: return 32'd50;
                endcase
            end
            default: return $urandom_range(0, 32'(PCT_FULL));
        endcase
    endfunction

    task automatic run_random(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_beat(OP_TICK, draw_q16(), draw_q16(), draw_q16(), $urandom());
            else if (pick < 88)
                send_beat(OP_REC, $urandom(), $urandom(), $urandom(), draw_percent());
            else if (pick < 94)
                send_beat(OP_RESTART, $urandom(), $urandom(), $urandom(), $urandom());
            else
                send_beat(OP_UNUSED, $urandom(), $urandom(), $urandom(), $urandom());
        end
    endtask

    // Lowers valid, waits for every predicted command to arrive and then
    // lets a beat that gives no command finish inside the block.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (commands_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input profile_t prof, input int count, input bit quiet_tx,
                             input bit quiet_rx, input int hold);
        apply_settings(prof);
        tx_no_idle     = quiet_tx;
        rx_no_idle     = quiet_rx;
        rx_hold_cycles = hold;
        run_random(count);
        drain();
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values of the registers: an ignored code while unloaded, the
        // loading tick, then two ticks that give commands.
        send_beat(OP_UNUSED, '1, '1, '1, '1);
        send_beat(OP_TICK, 32'h0001_0000, 32'h0000_8000, '0, '0);
        send_beat(OP_TICK, 32'h0003_0000, '0, 32'h0000_4000, '0);
        send_beat(OP_TICK, 32'hFFFE_0000, 32'h0002_0000, 32'hFFFF_0000, '0);
        drain();

        // Directed beats under fixed settings with a deadband of two.
        apply_settings(PROF_BENCH);
        send_beat(OP_UNUSED, 32'h1234_5678, '1, '1, '1);
        // Torque exactly on each edge of the deadband, and just outside it.
        send_beat(OP_TICK, 32'h0002_0000, '0, 32'h0002_0000, '0);
        send_beat(OP_TICK, 32'h0002_0000, '0, 32'h0002_0001, '0);
        send_beat(OP_TICK, '0, 32'h0001_0000, 32'hFFFE_0000, '0);
        send_beat(OP_TICK, '0, 32'h0001_0000, 32'hFFFD_FFFF, '0);
        // Recommendations beyond, on and inside the percent limits.
        send_beat(OP_REC, '0, '0, '0, 32'h7FFF_FFFF);
        send_beat(OP_TICK, 32'h0004_0000, '0, '0, '0);
        send_beat(OP_REC, '0, '0, '0, 32'(PCT_FULL) + 1);
        send_beat(OP_REC, '0, '0, '0, 32'(PCT_FULL));
        send_beat(OP_TICK, 32'h0004_0000, '0, '0, '0);
        send_beat(OP_REC, '0, '0, '0, 32'd49);
        send_beat(OP_REC, '0, '0, '0, 32'd50);
        send_beat(OP_TICK, 32'hFFFC_0000, '0, '0, '0);
        send_beat(OP_REC, '0, '0, '0, '1);
        send_beat(OP_REC, '0, '0, '0, 32'h8000_0000);
        send_beat(OP_TICK, 32'hFFFC_0000, '0, '0, '0);
        // Restart, reload at the signed extremes, then drive into saturation.
        send_beat(OP_RESTART, '0, '0, '0, '0);
        send_beat(OP_TICK, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
        send_beat(OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
        send_beat(OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0);
        send_beat(OP_RESTART, '0, '0, '0, '0);
        drain();

        // Random beats under a series of settings. The last but one keeps the
        // sender busy while the sink holds off for a long stretch.
        run_phase(PROF_TYPICAL,  150, 1'b0, 1'b0, 0);
        run_phase(PROF_CEILING,   90, 1'b0, 1'b0, 0);
        run_phase(PROF_ZERO,      60, 1'b0, 1'b0, 0);
        run_phase(PROF_DOWNWARD,  90, 1'b0, 1'b0, 0);
        run_phase(PROF_WILD,     100, 1'b0, 1'b0, 0);
        run_phase(PROF_TYPICAL,  100, 1'b1, 1'b1, 0);
        run_phase(PROF_TYPICAL,   80, 1'b1, 1'b0, HOLD_CYCLES);
        run_phase(PROF_BENCH,     80, 1'b0, 1'b0, 0);

        $display("Summary: %0d input beats under %0d register settings, %0d commands compared.",
                 beats_sent, settings_applied, commands_checked);
        $display({"Summary: settings ranged from all-zero to all-ones, with a downward ",
                  "stiffness range, bursts without idling and a long result hold-off."});
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/jis_pkg.sv
sv/jis_ctrl.sv
sv/jis_dp.sv
sv/joint_impedance_step.sv
bench/impedance_checker.sv
bench/tb_joint_impedance_step.sv
